// File: src/ppp_pkg.sv
// Shared widths, register codes and the job record passed from front to back.
package ppp_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 20;
   localparam int PIDX_W      = INDEX_BITS + 1;
   localparam int OFF_W       = 17;
   localparam int HEIGHT_W    = SAMPLE_BITS + 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 1;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] REG_INCLUDE_EDGES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_ON     = 1'd1;

   typedef struct packed {
      logic                          int_valid;
      logic                          interp;
      logic [PIDX_W-1:0]             int_index;
      logic signed [SAMPLE_BITS-1:0] int_sample;
      logic                          a_ge_b;
      logic [SAMPLE_BITS-1:0]        diff;
      logic [SAMPLE_BITS:0]          sum;
      logic                          edge_valid;
      logic [PIDX_W-1:0]             edge_index;
      logic signed [SAMPLE_BITS-1:0] edge_sample;
   } job_type;

   typedef struct packed {
      logic                               valid;
      logic                               full;
      logic [$clog2(QUEUE_DEPTH+1)-1:0]   count;
   } q_status_type;

endpackage

// File: src/ppp_req_if.sv
// Sample channel interface.
interface ppp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ppp_pkg::SAMPLE_BITS-1:0] sample;
   logic                                   last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink (input valid, sample, last_sample, output ready);
endinterface

// File: src/ppp_rsp_if.sv
// Peak result channel interface.
interface ppp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ppp_pkg::PIDX_W-1:0]          peak_index;
   logic signed [ppp_pkg::OFF_W-1:0]    offset_frac;
   logic signed [ppp_pkg::HEIGHT_W-1:0] peak_height;
   logic                                is_edge;
   logic                                last_of_run;

   modport source (output valid, peak_index, offset_frac, peak_height, is_edge, last_of_run,
                   input ready);
   modport sink (input valid, peak_index, offset_frac, peak_height, is_edge, last_of_run,
                 output ready);
endinterface

// File: src/ppp_front.sv
// Front end: sample history, peak classification and configuration registers.
module ppp_front (
   input  logic                             clock,
   input  logic                             reset,
   ppp_req_if.sink                          req,
   input  logic                             csr_we,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  ppp_pkg::q_status_type            q_stat,
   output logic                             push,
   output ppp_pkg::job_type                 job
);
   import ppp_pkg::*;

   localparam logic [INDEX_BITS-1:0] CNT_MAX = {INDEX_BITS{1'b1}};
   localparam logic [INDEX_BITS-1:0] CNT_ONE = INDEX_BITS'(1);

   logic                          edges_ff, edges_in;
   logic                          interp_ff, interp_in;
   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_BITS-1:0] pprev_ff, pprev_in;
   logic [INDEX_BITS-1:0]         cnt_ff, cnt_in;

   logic                          accept;
   logic [PIDX_W-1:0]             num;
   logic                          first_edge, interior, last_edge;
   logic signed [SAMPLE_BITS:0]   a_full, b_full;
   logic [SAMPLE_BITS-1:0]        a_mag, b_mag;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign num       = {1'b0, cnt_ff} + PIDX_W'(1);

   assign first_edge = (cnt_ff == CNT_ONE) && edges_ff && (prev_ff > req.sample);
   assign interior   = (cnt_ff > CNT_ONE) && (prev_ff > pprev_ff) && (prev_ff >= req.sample);
   assign last_edge  = req.last_sample && (cnt_ff != '0) && edges_ff && (req.sample > prev_ff);

   // Both differences are positive or zero whenever the job is an interior peak.
   assign a_full = {prev_ff[SAMPLE_BITS-1], prev_ff} - {pprev_ff[SAMPLE_BITS-1], pprev_ff};
   assign b_full = {prev_ff[SAMPLE_BITS-1], prev_ff} - {req.sample[SAMPLE_BITS-1], req.sample};
   assign a_mag  = a_full[SAMPLE_BITS-1:0];
   assign b_mag  = b_full[SAMPLE_BITS-1:0];

   always_comb begin
      job.int_valid   = interior;
      job.interp      = interp_ff;
      job.int_index   = num - PIDX_W'(1);
      job.int_sample  = prev_ff;
      job.a_ge_b      = a_mag >= b_mag;
      job.diff        = (a_mag >= b_mag) ? (a_mag - b_mag) : (b_mag - a_mag);
      job.sum         = {1'b0, a_mag} + {1'b0, b_mag};
      job.edge_valid  = first_edge || last_edge;
      job.edge_index  = first_edge ? PIDX_W'(1) : num;
      job.edge_sample = first_edge ? prev_ff : req.sample;
   end

   assign push = accept && (interior || first_edge || last_edge);

   always_comb begin
      edges_in  = edges_ff;
      interp_in = interp_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_INCLUDE_EDGES: edges_in  = csr_wdata[0];
            REG_INTERP_ON:     interp_in = csr_wdata[0];
            default: ;
         endcase
      end
      prev_in  = prev_ff;
      pprev_in = pprev_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         if (req.last_sample) begin
            prev_in  = '0;
            pprev_in = '0;
            cnt_in   = '0;
         end else begin
            prev_in  = req.sample;
            pprev_in = prev_ff;
            if (cnt_ff != CNT_MAX) begin
               cnt_in = cnt_ff + CNT_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff  <= 1'b0;
         interp_ff <= 1'b1;
         prev_ff   <= '0;
         pprev_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         edges_ff  <= edges_in;
         interp_ff <= interp_in;
         prev_ff   <= prev_in;
         pprev_ff  <= pprev_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: src/ppp_queue.sv
// Short job queue between the front end and the arithmetic back end.
module ppp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ppp_pkg::job_type      push_job,
   input  logic                  pop,
   output ppp_pkg::job_type      head_job,
   output ppp_pkg::q_status_type q_stat
);
   import ppp_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign do_push = push && (count_ff != CW'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   assign head_job     = entry_ff[rd_ff];
   assign q_stat.valid = count_ff != '0;
   assign q_stat.full  = count_ff == CW'(QUEUE_DEPTH);
   assign q_stat.count = count_ff;

   always_comb begin
      wr_in    = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: src/ppp_back.sv
// Back end: serial square and division for interpolation, and the result register.
module ppp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ppp_pkg::q_status_type q_stat,
   input  ppp_pkg::job_type      head_job,
   output logic                  pop,
   ppp_rsp_if.source             rsp
);
   import ppp_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int NW  = (2 * SB + 4 > SB + 18) ? 2 * SB + 4 : SB + 18;
   localparam int DW  = SB + 2;
   localparam int CW  = $clog2(NW);
   localparam int HW  = SB + 6;
   localparam logic signed [HW-1:0] HMAX = HW'((64'sd1 <<< (HEIGHT_W - 1)) - 1);
   localparam logic signed [HW-1:0] HMIN = -HMAX - HW'(1);

   typedef enum logic [2:0] {
      S_IDLE, S_SQR, S_DIVO, S_DIVH, S_OUT_INT, S_OUT_EDGE
   } state_type;

   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [2*SB-1:0]         mcand_ff, mcand_in;
   logic [SB-1:0]           mplier_ff, mplier_in;
   logic [2*SB-1:0]         prod_ff, prod_in;
   logic [NW-1:0]           num_ff, num_in;
   logic [NW-1:0]           quo_ff, quo_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           den_ff, den_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic signed [OFF_W-1:0] off_ff, off_in;
   logic [PIDX_W-1:0]       idx_ff, idx_in;
   logic signed [HEIGHT_W-1:0] ht_ff, ht_in;
   logic                    edge_ff, edge_in;
   logic                    lor_ff, lor_in;

   logic [DW:0]             shifted;
   logic                    ge;
   logic [DW-1:0]           rem_step;
   logic [NW-1:0]           quo_step;
   logic [OFF_W-1:0]        mag;
   logic signed [HW-1:0]    ht_sum;

   // One restoring division step per cycle.
   assign shifted  = {rem_ff, num_ff[NW-1]};
   assign ge       = shifted >= {1'b0, den_ff};
   assign rem_step = ge ? DW'(shifted - {1'b0, den_ff}) : shifted[DW-1:0];
   assign quo_step = {quo_ff[NW-2:0], ge};
   assign mag      = quo_step[OFF_W-1:0];
   assign ht_sum   = {{2{job_ff.int_sample[SB-1]}}, job_ff.int_sample, 4'b0000}
                     + {3'b000, quo_step[SB+2:0]};

   assign pop         = (state_ff == S_IDLE) && q_stat.valid;
   assign rsp.valid   = (state_ff == S_OUT_INT) || (state_ff == S_OUT_EDGE);
   assign rsp.peak_index  = idx_ff;
   assign rsp.offset_frac = off_ff;
   assign rsp.peak_height = ht_ff;
   assign rsp.is_edge     = edge_ff;
   assign rsp.last_of_run = lor_ff;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      off_in    = off_ff;
      idx_in    = idx_ff;
      ht_in     = ht_ff;
      edge_in   = edge_ff;
      lor_in    = lor_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_stat.valid) begin
               job_in = head_job;
               if (head_job.int_valid && head_job.interp) begin
                  mcand_in  = {{SB{1'b0}}, head_job.diff};
                  mplier_in = head_job.diff;
                  prod_in   = '0;
                  cnt_in    = '0;
                  state_in  = S_SQR;
               end else if (head_job.int_valid) begin
                  idx_in   = head_job.int_index;
                  off_in   = '0;
                  ht_in    = {head_job.int_sample, 4'b0000};
                  edge_in  = 1'b0;
                  lor_in   = !head_job.edge_valid;
                  state_in = S_OUT_INT;
               end else begin
                  idx_in   = head_job.edge_index;
                  off_in   = '0;
                  ht_in    = {head_job.edge_sample, 4'b0000};
                  edge_in  = 1'b1;
                  lor_in   = 1'b1;
                  state_in = S_OUT_EDGE;
               end
            end
         end
         S_SQR: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SB - 1)) begin
               // Offset magnitude is floor((d * 2^16 + s) / (2 * s)).
               num_in   = (NW'(job_ff.diff) << 16) + NW'(job_ff.sum);
               den_in   = {job_ff.sum, 1'b0};
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVO;
            end
         end
         S_DIVO: begin
            num_in = num_ff << 1;
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) begin
               off_in = job_ff.a_ge_b ? $signed(mag) : -$signed(mag);
               // Height correction is floor((4 * d^2 + s) / (2 * s)).
               num_in   = NW'({prod_ff, 2'b00}) + NW'(job_ff.sum);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVH;
            end
         end
         S_DIVH: begin
            num_in = num_ff << 1;
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) begin
               if (ht_sum > HMAX) begin
                  ht_in = HMAX[HEIGHT_W-1:0];
               end else if (ht_sum < HMIN) begin
                  ht_in = HMIN[HEIGHT_W-1:0];
               end else begin
                  ht_in = ht_sum[HEIGHT_W-1:0];
               end
               idx_in   = job_ff.int_index;
               edge_in  = 1'b0;
               lor_in   = !job_ff.edge_valid;
               state_in = S_OUT_INT;
            end
         end
         S_OUT_INT: begin
            if (rsp.ready) begin
               if (job_ff.edge_valid) begin
                  idx_in   = job_ff.edge_index;
                  off_in   = '0;
                  ht_in    = {job_ff.edge_sample, 4'b0000};
                  edge_in  = 1'b1;
                  lor_in   = 1'b1;
                  state_in = S_OUT_EDGE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT_EDGE: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff    <= job_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      cnt_ff    <= cnt_in;
      off_ff    <= off_in;
      idx_ff    <= idx_in;
      ht_ff     <= ht_in;
      edge_ff   <= edge_in;
      lor_ff    <= lor_in;
   end

endmodule

// File: src/peak_picker_parabolic_unit.sv
// Top level of the streaming peak picker with parabolic interpolation.
//
//   channel  direction  beat contents
//   req      in         sample, last_sample
//   rsp      out        peak_index, offset_frac, peak_height, is_edge, last_of_run
//   csr      in         csr_we, csr_index, csr_wdata (write only)
//
// A sample beat is taken whenever the four-entry job queue has room.
// An interpolated peak occupies the back end for a load step, a serial square
// and two divisions (offset, then height), then its result beats; any other job
// takes the load step plus its result beats.
// A stalled result holds the back end only; the front keeps filling the queue.
// Reset is synchronous and clears history, queue and sequencer at once.
module peak_picker_parabolic_unit (
   input  logic                           clock,
   input  logic                           reset,
   ppp_req_if.sink                        req,
   ppp_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ppp_pkg::*;

   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head_job;
   q_status_type q_stat;

   ppp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .push      (push),
      .job       (push_job)
   );

   ppp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   ppp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp)
   );

   // An edge peak is always the final result of its sample.
   a_edge_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_edge |-> rsp.last_of_run)
      else $error("edge peak without last_of_run");

   a_edge_off: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_edge |-> rsp.offset_frac == '0)
      else $error("edge peak with nonzero offset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req.ready && !push)
      else $error("sample taken while job queue full");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.valid && !rsp.valid)
      else $error("job popped from empty queue or during a result beat");

endmodule
